[rtl/assert_macros.svh]
// Assertion macros used by the checker file of the dosing command safety gate.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that is checked only while the block is out of reset.
`define DCSG_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("dosing command safety gate assertion failed");

// A property that is checked on every clock edge, reset included.
`define DCSG_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("dosing command safety gate assertion failed");

`endif

[rtl/dcsg_pkg.sv]
// Types and constants of the dosing command safety gate.
package dcsg_pkg;

  localparam int CFG_ADDR_W = 5;

  localparam logic [2:0] ACT_NO_CHANGE  = 3'd0;
  localparam logic [2:0] ACT_SUSPEND    = 3'd1;
  localparam logic [2:0] ACT_INCREASE   = 3'd2;
  localparam logic [2:0] ACT_CORRECTION = 3'd3;

  localparam int RSN_STALE   = 0;
  localparam int RSN_BADQ    = 1;
  localparam int RSN_LOW15   = 2;
  localparam int RSN_LOW30   = 3;
  localparam int RSN_FALL    = 4;
  localparam int RSN_IOB     = 5;
  localparam int RSN_BADGLU  = 6;
  localparam int RSN_LOWCONF = 7;
  localparam int RSN_NOPHYS  = 8;
  localparam int RSN_BLOCKED = 9;

  localparam logic [2:0] REG_MIN_GLUCOSE = 3'd0;
  localparam logic [2:0] REG_MAX_GLUCOSE = 3'd1;
  localparam logic [2:0] REG_LOW_PRED    = 3'd2;
  localparam logic [2:0] REG_MIN_QUALITY = 3'd3;
  localparam logic [2:0] REG_MAX_AGE     = 3'd4;
  localparam logic [2:0] REG_MAX_BASAL   = 3'd5;
  localparam logic [2:0] REG_MAX_IOB     = 3'd6;

  typedef struct packed {
    logic [9:0]  min_valid_glucose;
    logic [9:0]  max_valid_glucose;
    logic [9:0]  low_prediction_limit;
    logic [6:0]  min_quality_pct;
    logic [31:0] max_reading_age;
    logic [15:0] max_basal_rate;
    logic [15:0] max_insulin_on_board;
  } cfg_t;

endpackage

[rtl/dcsg_cfg_regs.sv]
// Configuration register file of the dosing command safety gate.
module dcsg_cfg_regs
  import dcsg_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready,
  output cfg_t                  cfg
);

  cfg_t       cfg_r;
  cfg_t       cfg_nxt;
  logic [2:0] reg_idx;
  logic       wr_en;

  assign reg_idx    = cfg_paddr[CFG_ADDR_W-1:2];
  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg        = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx)
        REG_MIN_GLUCOSE: cfg_nxt.min_valid_glucose    = cfg_pwdata[9:0];
        REG_MAX_GLUCOSE: cfg_nxt.max_valid_glucose    = cfg_pwdata[9:0];
        REG_LOW_PRED:    cfg_nxt.low_prediction_limit = cfg_pwdata[9:0];
        REG_MIN_QUALITY: cfg_nxt.min_quality_pct      = cfg_pwdata[6:0];
        REG_MAX_AGE:     cfg_nxt.max_reading_age      = cfg_pwdata;
        REG_MAX_BASAL:   cfg_nxt.max_basal_rate       = cfg_pwdata[15:0];
        REG_MAX_IOB:     cfg_nxt.max_insulin_on_board = cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_valid_glucose    <= 10'd40;
      cfg_r.max_valid_glucose    <= 10'd400;
      cfg_r.low_prediction_limit <= 10'd80;
      cfg_r.min_quality_pct      <= 7'd60;
      cfg_r.max_reading_age      <= 32'd600;
      cfg_r.max_basal_rate       <= 16'd200;
      cfg_r.max_insulin_on_board <= 16'd500;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_MIN_GLUCOSE: cfg_prdata = {22'd0, cfg_r.min_valid_glucose};
      REG_MAX_GLUCOSE: cfg_prdata = {22'd0, cfg_r.max_valid_glucose};
      REG_LOW_PRED:    cfg_prdata = {22'd0, cfg_r.low_prediction_limit};
      REG_MIN_QUALITY: cfg_prdata = {25'd0, cfg_r.min_quality_pct};
      REG_MAX_AGE:     cfg_prdata = cfg_r.max_reading_age;
      REG_MAX_BASAL:   cfg_prdata = {16'd0, cfg_r.max_basal_rate};
      REG_MAX_IOB:     cfg_prdata = {16'd0, cfg_r.max_insulin_on_board};
      default:         cfg_prdata = 32'd0;
    endcase
  end

endmodule

[rtl/dosing_command_safety_gate.sv]
// Top level of the dosing command safety gate: a three-stage rule pipeline.
//
// Channel   Direction   Handshake          Contents
// in_*      input       in_valid/in_stall  one proposed command with sensor data
// out_*     output      out_valid/out_stall one checked command with reason word
// cfg_*     input       APB-style          seven limit registers
//
// An accepted request passes the stage one, stage two and output registers before
// it is offered as a result; one request can be accepted in every cycle while
// in_stall is low.
// Stage one compares the reading age and each limit but the basal one, stage two
// applies the overrides, and stage three sets the blocked bit and basal clamp.
// Each stage moves on when the stage after it is empty or moving, so a stalled
// result holds only the stages that are full behind it.
// Reset clears the valid bits and loads the register defaults.
module dosing_command_safety_gate
  import dcsg_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [31:0]           in_now_seconds,
  input  logic [31:0]           in_reading_time,
  input  logic [15:0]           in_glucose_reading,
  input  logic [31:0]           in_predicted_pair,
  input  logic [6:0]            in_pred_confidence,
  input  logic [6:0]            in_quality_pct,
  input  logic [2:0]            in_status_bits,
  input  logic [15:0]           in_insulin_on_board,
  input  logic [2:0]            in_proposed_action,
  input  logic [15:0]           in_proposed_basal,
  input  logic [15:0]           in_proposed_correction,
  input  logic [15:0]           in_prior_reasons,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [2:0]            out_final_action,
  output logic [15:0]           out_final_basal,
  output logic [15:0]           out_final_correction,
  output logic [15:0]           out_reason_word,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);

  cfg_t cfg;

  dcsg_cfg_regs u_cfg_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  typedef struct packed {
    logic stale;
    logic badglu;
    logic low15;
    logic low30;
    logic fall;
    logic lowconf;
    logic badq;
    logic xiob;
    logic nophys;
  } flags_t;

  logic        v1_r, v2_r, v3_r;
  logic        ready1, ready2, ready3;

  flags_t      s1_flags_r, s1_flags_nxt;
  logic [2:0]  s1_act_r;
  logic [15:0] s1_bas_r, s1_cor_r, s1_rsn_r;
  logic [31:0] age;

  logic        s2_early_r, s2_early_nxt;
  logic        s2_changed_r, s2_changed_nxt;
  logic [2:0]  s2_act_r, s2_act_nxt;
  logic [15:0] s2_bas_r, s2_bas_nxt;
  logic [15:0] s2_cor_r, s2_cor_nxt;
  logic [15:0] s2_rsn_r, s2_rsn_nxt;
  logic        is_inc, veto, suspend;

  logic [2:0]  out_act_r;
  logic [15:0] out_bas_r, out_cor_r, out_rsn_r;
  logic [15:0] bas_clamped;
  logic [15:0] rsn_final;

  assign ready3   = !v3_r || !out_stall;
  assign ready2   = !v2_r || ready3;
  assign ready1   = !v1_r || ready2;
  assign in_stall = !ready1;

  // Stage one: limit comparisons.
  assign age = in_now_seconds - in_reading_time;

  always_comb begin
    s1_flags_nxt.stale   = (in_reading_time == 32'd0) || (age > cfg.max_reading_age);
    s1_flags_nxt.badglu  = (in_glucose_reading < {6'd0, cfg.min_valid_glucose}) ||
                           (in_glucose_reading > {6'd0, cfg.max_valid_glucose});
    s1_flags_nxt.low15   = in_predicted_pair[15:0] <= {6'd0, cfg.low_prediction_limit};
    s1_flags_nxt.low30   = in_predicted_pair[31:16] <= {6'd0, cfg.low_prediction_limit};
    s1_flags_nxt.fall    = in_status_bits[1];
    s1_flags_nxt.lowconf = in_pred_confidence < cfg.min_quality_pct;
    s1_flags_nxt.badq    = (in_quality_pct < cfg.min_quality_pct) || in_status_bits[0];
    s1_flags_nxt.xiob    = in_insulin_on_board >= cfg.max_insulin_on_board;
    s1_flags_nxt.nophys  = !in_status_bits[2];
  end

  // Stage two: overrides and reason bits.
  assign is_inc  = (s1_act_r == ACT_INCREASE) || (s1_act_r == ACT_CORRECTION);
  assign veto    = s1_flags_r.badq || s1_flags_r.lowconf || s1_flags_r.xiob ||
                   s1_flags_r.nophys;
  assign suspend = s1_flags_r.low15 || s1_flags_r.low30 || s1_flags_r.fall;

  always_comb begin
    s2_early_nxt = s1_flags_r.stale || s1_flags_r.badglu;
    s2_act_nxt   = s1_act_r;
    s2_bas_nxt   = s1_bas_r;
    s2_cor_nxt   = s1_cor_r;
    s2_rsn_nxt   = s1_rsn_r;
    if (s2_early_nxt) begin
      s2_act_nxt = ACT_NO_CHANGE;
      s2_bas_nxt = 16'd0;
      s2_cor_nxt = 16'd0;
      s2_rsn_nxt[RSN_STALE]  = s1_rsn_r[RSN_STALE] | s1_flags_r.stale;
      s2_rsn_nxt[RSN_BADGLU] = s1_rsn_r[RSN_BADGLU] | s1_flags_r.badglu;
    end else begin
      s2_rsn_nxt[RSN_LOW15]   = s1_rsn_r[RSN_LOW15] | s1_flags_r.low15;
      s2_rsn_nxt[RSN_LOW30]   = s1_rsn_r[RSN_LOW30] | s1_flags_r.low30;
      s2_rsn_nxt[RSN_FALL]    = s1_rsn_r[RSN_FALL] | s1_flags_r.fall;
      s2_rsn_nxt[RSN_LOWCONF] = s1_rsn_r[RSN_LOWCONF] | s1_flags_r.lowconf;
      s2_rsn_nxt[RSN_BADQ]    = s1_rsn_r[RSN_BADQ] | s1_flags_r.badq;
      s2_rsn_nxt[RSN_IOB]     = s1_rsn_r[RSN_IOB] | s1_flags_r.xiob;
      s2_rsn_nxt[RSN_NOPHYS]  = s1_rsn_r[RSN_NOPHYS] | s1_flags_r.nophys;
      if (suspend) begin
        s2_act_nxt = ACT_SUSPEND;
        s2_bas_nxt = 16'd0;
        s2_cor_nxt = 16'd0;
      end else if (is_inc && veto) begin
        s2_act_nxt = ACT_NO_CHANGE;
        s2_bas_nxt = 16'd0;
        s2_cor_nxt = 16'd0;
      end
    end
    s2_changed_nxt = (s2_act_nxt != s1_act_r) || (s2_bas_nxt != s1_bas_r) ||
                     (s2_cor_nxt != s1_cor_r);
  end

  // Stage three: blocked bit and basal clamp.
  always_comb begin
    rsn_final = s2_rsn_r;
    if (s2_changed_r && (s2_early_r || (s2_rsn_r[RSN_NOPHYS:RSN_STALE] != 9'd0))) begin
      rsn_final[RSN_BLOCKED] = 1'b1;
    end
    bas_clamped = (s2_bas_r > cfg.max_basal_rate) ? cfg.max_basal_rate : s2_bas_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (ready1) begin
        v1_r <= in_valid;
      end
      if (ready2) begin
        v2_r <= v1_r;
      end
      if (ready3) begin
        v3_r <= v2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready1 && in_valid) begin
      s1_flags_r <= s1_flags_nxt;
      s1_act_r   <= in_proposed_action;
      s1_bas_r   <= in_proposed_basal;
      s1_cor_r   <= in_proposed_correction;
      s1_rsn_r   <= in_prior_reasons;
    end
    if (ready2 && v1_r) begin
      s2_early_r   <= s2_early_nxt;
      s2_changed_r <= s2_changed_nxt;
      s2_act_r     <= s2_act_nxt;
      s2_bas_r     <= s2_bas_nxt;
      s2_cor_r     <= s2_cor_nxt;
      s2_rsn_r     <= s2_rsn_nxt;
    end
    if (ready3 && v2_r) begin
      out_act_r <= s2_act_r;
      out_bas_r <= bas_clamped;
      out_cor_r <= s2_cor_r;
      out_rsn_r <= rsn_final;
    end
  end

  assign out_valid            = v3_r;
  assign out_final_action     = out_act_r;
  assign out_final_basal      = out_bas_r;
  assign out_final_correction = out_cor_r;
  assign out_reason_word      = out_rsn_r;

endmodule

[rtl/dcsg_checker.sv]
// Port-level assertions of the dosing command safety gate and their bind.
`include "assert_macros.svh"

module dcsg_checker
  import dcsg_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [31:0] in_reading_time,
  input logic [15:0] in_prior_reasons,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  out_final_action,
  input logic [15:0] out_final_basal,
  input logic [15:0] out_final_correction,
  input logic [15:0] out_reason_word
);

  // No result may be offered in the cycle after reset.
  property p_no_out_after_reset;
    $past(!rst_n) |-> !out_valid;
  endproperty

  // A stalled result stays offered and unchanged.
  property p_out_hold;
    out_valid && out_stall |=> out_valid && $stable(out_final_action) &&
      $stable(out_final_basal) && $stable(out_final_correction) && $stable(out_reason_word);
  endproperty

  // With a free output an accepted request is offered with its upper reason bits unchanged.
  property p_latency_pass;
    (in_valid && !in_stall) ##1 !out_stall ##1 !out_stall |=>
      out_valid && (out_reason_word[15:10] == $past(in_prior_reasons[15:10], 3));
  endproperty

  // A request without a reading time stamp leaves as no change with zero doses.
  property p_missing_stamp;
    (in_valid && !in_stall && (in_reading_time == 32'd0)) ##1 !out_stall ##1 !out_stall |=>
      out_valid && (out_final_action == ACT_NO_CHANGE) && (out_final_basal == 16'd0) &&
      (out_final_correction == 16'd0) && out_reason_word[RSN_STALE];
  endproperty

  `DCSG_ASSERT_ALWAYS(a_no_out_after_reset, clk, p_no_out_after_reset)
  `DCSG_ASSERT(a_out_hold, clk, rst_n, p_out_hold)
  `DCSG_ASSERT(a_latency_pass, clk, rst_n, p_latency_pass)
  `DCSG_ASSERT(a_missing_stamp, clk, rst_n, p_missing_stamp)

endmodule

bind dosing_command_safety_gate dcsg_checker u_dcsg_checker (.*);
